@@ rtl/i2cebas_pkg.sv @@
`timescale 1ns / 1ps

package i2cebas_pkg;

  // Field widths
  localparam int ADDR_BITS   = 16;
  localparam int RETRY_BITS  = 4;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 24;

  // Reset value of the retry limit
  localparam logic [RETRY_BITS-1:0] MAX_RETRIES_RST = 4'd5;

  // Input item kinds (carried in s_tuser)
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  // Bus engine status codes, low three bits masked off
  localparam logic [7:0] STATUS_MASK   = 8'hF8;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_REP_START  = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NAK = 8'h20;
  localparam logic [7:0] ST_MT_DAT_ACK = 8'h28;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NAK = 8'h48;
  localparam logic [7:0] ST_MR_DAT_NAK = 8'h58;

  // Actions issued to the bus engine (carried in m_tuser)
  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_SEND  = 3'd1;
  localparam logic [2:0] ACT_RECV  = 3'd2;
  localparam logic [2:0] ACT_STOP  = 3'd3;
  localparam logic [2:0] ACT_DONE  = 3'd4;

  // One result item
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       success;
    logic [7:0] read_byte;
    logic       last;
  } result_t;

  // All results caused by one input item (one or two)
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } result_pair_t;

endpackage

@@ rtl/i2cebas_seq.sv @@
`timescale 1ns / 1ps

module i2cebas_seq (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [i2cebas_pkg::RETRY_BITS-1:0]     cfg_data,
  input  logic                                   accept,
  input  logic [1:0]                             cmd,
  input  logic [i2cebas_pkg::ADDR_BITS-1:0]      mem_addr,
  input  logic [3:0]                             dev_code,
  input  logic [2:0]                             chip_sel,
  input  logic [7:0]                             wr_data,
  input  logic [7:0]                             bus_status,
  input  logic [7:0]                             rx_data,
  output logic                                   push,
  output i2cebas_pkg::result_pair_t              pair
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_SLAW, PH_ADDRH, PH_ADDRL,
    PH_DATA, PH_RSTART, PH_SLAR, PH_RX
  } phase_t;

  phase_t                                phase, phase_next;
  logic [i2cebas_pkg::RETRY_BITS-1:0]    max_retries;
  logic [i2cebas_pkg::RETRY_BITS-1:0]    attempt, attempt_next;
  logic                                  is_read, is_read_next;
  logic [i2cebas_pkg::ADDR_BITS-1:0]     addr_latch, addr_latch_next;
  logic [6:0]                            slave_latch, slave_latch_next;
  logic [7:0]                            data_latch, data_latch_next;
  logic [7:0]                            st;
  logic [7:0]                            sla;
  logic                                  can_retry;

  function automatic i2cebas_pkg::result_t mk(input logic [2:0] act, input logic [7:0] tx,
                                              input logic ok, input logic [7:0] rd,
                                              input logic lst);
    i2cebas_pkg::result_t r;
    r.action    = act;
    r.tx_byte   = tx;
    r.success   = ok;
    r.read_byte = rd;
    r.last      = lst;
    return r;
  endfunction

  // Optional stop, then the finished report
  function automatic i2cebas_pkg::result_pair_t finish(input logic more, input logic ok,
                                                       input logic [7:0] rd);
    i2cebas_pkg::result_pair_t p;
    i2cebas_pkg::result_t      done;
    done = mk(i2cebas_pkg::ACT_DONE, 8'd0, ok, rd, 1'b1);
    if (more) begin
      p.r0  = mk(i2cebas_pkg::ACT_STOP, 8'd0, 1'b0, 8'd0, 1'b0);
      p.r1  = done;
      p.two = 1'b1;
    end else begin
      p.r0  = done;
      p.r1  = done;
      p.two = 1'b0;
    end
    return p;
  endfunction

  function automatic i2cebas_pkg::result_pair_t single(input i2cebas_pkg::result_t r);
    i2cebas_pkg::result_pair_t p;
    p.r0  = r;
    p.r1  = r;
    p.two = 1'b0;
    return p;
  endfunction

  assign st        = bus_status & i2cebas_pkg::STATUS_MASK;
  assign sla       = {slave_latch, 1'b0};
  assign can_retry = attempt < max_retries;

  // Next state and results for one transfer
  always_comb begin
    phase_next       = phase;
    attempt_next     = attempt;
    is_read_next     = is_read;
    addr_latch_next  = addr_latch;
    slave_latch_next = slave_latch;
    data_latch_next  = data_latch;
    push             = 1'b0;
    pair             = single(mk(i2cebas_pkg::ACT_START, 8'd0, 1'b0, 8'd0, 1'b1));

    if (accept && (cmd == i2cebas_pkg::CMD_WRITE || cmd == i2cebas_pkg::CMD_READ)) begin
      if (phase == PH_IDLE) begin
        is_read_next     = (cmd == i2cebas_pkg::CMD_READ);
        addr_latch_next  = mem_addr;
        slave_latch_next = {dev_code, chip_sel};
        data_latch_next  = (cmd == i2cebas_pkg::CMD_WRITE) ? wr_data : 8'd0;
        attempt_next     = '0;
        phase_next       = PH_START;
        push             = 1'b1;
      end
    end else if (accept && cmd == i2cebas_pkg::CMD_EVENT && phase != PH_IDLE) begin
      push = 1'b1;
      case (phase)
        PH_START, PH_RSTART: begin
          if (st == i2cebas_pkg::ST_ARB_LOST) begin
            if (can_retry) begin
              attempt_next = attempt + 4'd1;
              phase_next   = PH_START;
            end else begin
              pair       = single(mk(i2cebas_pkg::ACT_DONE, 8'd0, 1'b0, 8'd0, 1'b1));
              phase_next = PH_IDLE;
            end
          end else if (st != i2cebas_pkg::ST_START && st != i2cebas_pkg::ST_REP_START) begin
            pair       = finish(can_retry, 1'b0, 8'd0);
            phase_next = PH_IDLE;
          end else if (phase == PH_START) begin
            pair       = single(mk(i2cebas_pkg::ACT_SEND, sla, 1'b0, 8'd0, 1'b1));
            phase_next = PH_SLAW;
          end else begin
            pair       = single(mk(i2cebas_pkg::ACT_SEND, sla | 8'd1, 1'b0, 8'd0, 1'b1));
            phase_next = PH_SLAR;
          end
        end
        PH_SLAW, PH_SLAR: begin
          if (st == i2cebas_pkg::ST_ARB_LOST ||
              (phase == PH_SLAW && st == i2cebas_pkg::ST_MT_SLA_NAK) ||
              (phase == PH_SLAR && st == i2cebas_pkg::ST_MR_SLA_NAK)) begin
            if (can_retry) begin
              attempt_next = attempt + 4'd1;
              phase_next   = PH_START;
            end else begin
              pair       = single(mk(i2cebas_pkg::ACT_DONE, 8'd0, 1'b0, 8'd0, 1'b1));
              phase_next = PH_IDLE;
            end
          end else if (phase == PH_SLAW && st == i2cebas_pkg::ST_MT_SLA_ACK) begin
            pair       = single(mk(i2cebas_pkg::ACT_SEND, addr_latch[15:8], 1'b0, 8'd0, 1'b1));
            phase_next = PH_ADDRH;
          end else if (phase == PH_SLAR && st == i2cebas_pkg::ST_MR_SLA_ACK) begin
            pair       = single(mk(i2cebas_pkg::ACT_RECV, 8'd0, 1'b0, 8'd0, 1'b1));
            phase_next = PH_RX;
          end else begin
            pair       = finish(can_retry, 1'b0, 8'd0);
            phase_next = PH_IDLE;
          end
        end
        PH_ADDRH: begin
          if (st != i2cebas_pkg::ST_MT_DAT_ACK) begin
            pair       = finish(can_retry, 1'b0, 8'd0);
            phase_next = PH_IDLE;
          end else begin
            pair       = single(mk(i2cebas_pkg::ACT_SEND, addr_latch[7:0], 1'b0, 8'd0, 1'b1));
            phase_next = PH_ADDRL;
          end
        end
        PH_ADDRL: begin
          if (st != i2cebas_pkg::ST_MT_DAT_ACK) begin
            pair       = finish(can_retry, 1'b0, 8'd0);
            phase_next = PH_IDLE;
          end else if (!is_read) begin
            pair       = single(mk(i2cebas_pkg::ACT_SEND, data_latch, 1'b0, 8'd0, 1'b1));
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_RSTART;
          end
        end
        PH_DATA: begin
          pair       = finish(can_retry, st == i2cebas_pkg::ST_MT_DAT_ACK, 8'd0);
          phase_next = PH_IDLE;
        end
        PH_RX: begin
          if (st != i2cebas_pkg::ST_MR_DAT_NAK) begin
            pair = finish(can_retry, 1'b0, 8'd0);
          end else begin
            data_latch_next = rx_data;
            pair            = finish(can_retry, 1'b1, is_read ? rx_data : 8'd0);
          end
          phase_next = PH_IDLE;
        end
        default: begin
          push       = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Hold sequence state and the retry limit
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      attempt     <= '0;
      is_read     <= 1'b0;
      addr_latch  <= '0;
      slave_latch <= '0;
      data_latch  <= '0;
      max_retries <= i2cebas_pkg::MAX_RETRIES_RST;
    end else begin
      phase       <= phase_next;
      attempt     <= attempt_next;
      is_read     <= is_read_next;
      addr_latch  <= addr_latch_next;
      slave_latch <= slave_latch_next;
      data_latch  <= data_latch_next;
      if (cfg_valid) begin
        max_retries <= cfg_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_two_is_stop_done: assert property (@(posedge clk) disable iff (rst)
    push && pair.two |-> pair.r0.action == i2cebas_pkg::ACT_STOP && !pair.r0.last &&
                         pair.r1.action == i2cebas_pkg::ACT_DONE && pair.r1.last)
    else $error("two-result transfer is not stop then finished");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    push && !pair.two |-> pair.r0.last)
    else $error("single result without last");
  a_tx_only_send: assert property (@(posedge clk) disable iff (rst)
    push && pair.r0.action != i2cebas_pkg::ACT_SEND |-> pair.r0.tx_byte == 8'd0)
    else $error("tx byte set on a non-send action");
  a_request_starts: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE &&
    (cmd == i2cebas_pkg::CMD_WRITE || cmd == i2cebas_pkg::CMD_READ)
    |=> phase == PH_START && attempt == '0)
    else $error("request did not start a fresh sequence");
`endif

endmodule

@@ rtl/i2cebas_outq.sv @@
`timescale 1ns / 1ps

module i2cebas_outq #(
  parameter int DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  i2cebas_pkg::result_pair_t             pair,
  output logic                                  ready,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [i2cebas_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [2:0]                            m_tuser,
  output logic                                  m_tlast
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2cebas_pkg::result_pair_t mem [DEPTH];
  logic [PW-1:0]             wr_ptr, rd_ptr;
  logic [CW-1:0]             count;
  logic                      sub;
  i2cebas_pkg::result_pair_t head;
  i2cebas_pkg::result_t      cur;
  logic                      xfer, pop;

  assign head     = mem[rd_ptr];
  assign cur      = sub ? head.r1 : head.r0;
  assign m_tvalid = (count != '0);
  assign ready    = (count < CW'(DEPTH));
  assign xfer     = m_tvalid && m_tready;
  assign pop      = xfer && (sub || !head.two);

  assign m_tdata = {7'd0, cur.read_byte, cur.success, cur.tx_byte};
  assign m_tuser = cur.action;
  assign m_tlast = cur.last;

  // Store result groups
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= pair;
    end
  end

  // Advance pointers, fill count and the second-result marker
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
        sub    <= 1'b0;
      end else if (xfer) begin
        sub <= 1'b1;
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count < CW'(DEPTH))
    else $error("result queue overflow");
  a_sub_needs_two: assert property (@(posedge clk) disable iff (rst)
    sub |-> m_tvalid && head.two)
    else $error("second result selected on a single-result group");
  a_pop_drops_count: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - CW'(1))
    else $error("fill count did not drop on pop");
`endif

endmodule

@@ rtl/i2c_eeprom_byte_access_sequencer.sv @@
`timescale 1ns / 1ps

// Single-byte random read/write sequencer for a 16-bit-address I2C memory.
// Slave channel (s_*): requests (write or read, kind in s_tuser) and status
// events from the bus engine. Master channel (m_*): actions for the bus
// engine (start, send byte, receive with NACK, stop) and a finished report;
// m_tlast marks the last result caused by one input transfer.
// cfg_*: writes the retry limit (highest attempt index); always ready.
// Each result is registered in the result queue before it appears on m_*.
// Throughput: one input transfer per cycle while the output keeps up; an
// input that ends a sequence with a stop yields two results, each taking
// its own output transfer. The result queue holds OUT_DEPTH result groups;
// s_tready drops only when that queue is full, so a stalled receiver
// backs up into the slave channel with no loss.
// Reset (rst, synchronous): sequencer idle, queue empty, retry limit 5.
// Requests during a sequence, events while idle and the unused kind are
// accepted and dropped with no result.
module i2c_eeprom_byte_access_sequencer #(
  parameter int OUT_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // mem_addr[15:0], dev_code[19:16], chip_sel[22:20], wr_data[30:23],
  // bus_status[38:31], rx_data[46:39], zero pad[47]
  input  logic [i2cebas_pkg::IN_DATA_W-1:0]     s_tdata,
  // cmd[1:0]
  input  logic [1:0]                            s_tuser,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // tx_byte[7:0], success[8], read_byte[16:9], zero pad[23:17]
  output logic [i2cebas_pkg::OUT_DATA_W-1:0]    m_tdata,
  // bus_action[2:0]
  output logic [2:0]                            m_tuser,
  output logic                                  m_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [i2cebas_pkg::RETRY_BITS-1:0]    cfg_data
);

  logic                      accept;
  logic                      push;
  i2cebas_pkg::result_pair_t pair;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  i2cebas_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .cmd        (s_tuser),
    .mem_addr   (s_tdata[15:0]),
    .dev_code   (s_tdata[19:16]),
    .chip_sel   (s_tdata[22:20]),
    .wr_data    (s_tdata[30:23]),
    .bus_status (s_tdata[38:31]),
    .rx_data    (s_tdata[46:39]),
    .push       (push),
    .pair       (pair)
  );

  i2cebas_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pair     (pair),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ sim/i2c_eeprom_byte_access_sequencer_test.sv @@
`timescale 1ns / 1ps

module i2c_eeprom_byte_access_sequencer_test;

  // Kind code that the block drops
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START, SEQ_SLA_W, SEQ_ADDR_HI, SEQ_ADDR_LO,
    SEQ_DATA, SEQ_RESTART, SEQ_SLA_R, SEQ_RX
  } seq_phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_addr;
    logic [3:0]  dev_code;
    logic [2:0]  chip_sel;
    logic [7:0]  wr_data;
    logic [7:0]  bus_status;
    logic [7:0]  rx_data;
  } seq_item_t;

  // One directed step: an input transfer or a retry limit write
  typedef struct {
    logic      is_limit;
    logic [3:0] limit;
    seq_item_t item;
    int        n_fixed;   // -1: take the actions from the predictor
    i2cebas_pkg::result_t fixed0;
    i2cebas_pkg::result_t fixed1;
  } plan_row_t;

  localparam i2cebas_pkg::result_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [i2cebas_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]                         s_tuser = i2cebas_pkg::CMD_WRITE;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [i2cebas_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [2:0]                         m_tuser;
  logic                               m_tlast;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [i2cebas_pkg::RETRY_BITS-1:0] cfg_data = '0;

  // Predictor state
  logic [3:0]  retry_limit = i2cebas_pkg::MAX_RETRIES_RST;
  seq_phase_t  seq_phase = SEQ_IDLE;
  logic [3:0]  attempt_q = '0;
  logic        read_q = 1'b0;
  logic [15:0] addr_q = '0;
  logic [6:0]  slave_q = '0;
  logic [7:0]  data_q = '0;
  i2cebas_pkg::result_t step_out [2];
  int          step_n = 0;

  i2cebas_pkg::result_t pending_actions [$];
  int      mismatches = 0;
  logic    in_calm = 1'b0;
  logic    out_calm = 1'b0;
  logic    flaky = 1'b0;
  plan_row_t plan [$];

  i2c_eeprom_byte_access_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic i2cebas_pkg::result_t outcome(input logic [2:0] act,
                                                   input logic [7:0] tx,
                                                   input logic ok, input logic [7:0] rd,
                                                   input logic lst);
    i2cebas_pkg::result_t r;
    r.action    = act;
    r.tx_byte   = tx;
    r.success   = ok;
    r.read_byte = rd;
    r.last      = lst;
    return r;
  endfunction

  function automatic seq_item_t request(input logic [1:0] cmd, input logic [15:0] addr,
                                        input logic [3:0] dev, input logic [2:0] chip,
                                        input logic [7:0] wr);
    seq_item_t it;
    it          = '0;
    it.cmd      = cmd;
    it.mem_addr = addr;
    it.dev_code = dev;
    it.chip_sel = chip;
    it.wr_data  = wr;
    return it;
  endfunction

  function automatic seq_item_t status_item(input logic [7:0] st, input logic [7:0] rx);
    seq_item_t it;
    it            = '0;
    it.cmd        = i2cebas_pkg::CMD_EVENT;
    it.bus_status = st;
    it.rx_data    = rx;
    return it;
  endfunction

  function automatic plan_row_t send_row(input seq_item_t it, input int n,
                                         input i2cebas_pkg::result_t f0 = NO_RESULT,
                                         input i2cebas_pkg::result_t f1 = NO_RESULT);
    plan_row_t p;
    p.is_limit = 1'b0;
    p.limit    = '0;
    p.item     = it;
    p.n_fixed  = n;
    p.fixed0   = f0;
    p.fixed1   = f1;
    return p;
  endfunction

  function automatic plan_row_t limit_row(input logic [3:0] v);
    plan_row_t p;
    p          = send_row('0, 0);
    p.is_limit = 1'b1;
    p.limit    = v;
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Predictor: append one action to the outputs of the current step
  task automatic emit_action(input logic [2:0] act, input logic [7:0] tx, input logic ok,
                             input logic [7:0] rd, input logic lst);
    step_out[step_n] = outcome(act, tx, ok, rd, lst);
    step_n++;
  endtask

  // End the access; a stop goes out only while attempts remain below the limit
  task automatic close_access(input logic ok);
    if (attempt_q < retry_limit) begin
      emit_action(i2cebas_pkg::ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    end
    emit_action(i2cebas_pkg::ACT_DONE, 8'h00, ok, (ok && read_q) ? data_q : 8'h00, 1'b1);
    seq_phase = SEQ_IDLE;
  endtask

  // Start over from the top, or give up once the limit is reached
  task automatic restart_access();
    if (attempt_q < retry_limit) begin
      attempt_q = attempt_q + 4'd1;
      seq_phase = SEQ_START;
      emit_action(i2cebas_pkg::ACT_START, 8'h00, 1'b0, 8'h00, 1'b1);
    end else begin
      emit_action(i2cebas_pkg::ACT_DONE, 8'h00, 1'b0, 8'h00, 1'b1);
      seq_phase = SEQ_IDLE;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input seq_phase_t next);
    seq_phase = next;
    emit_action(i2cebas_pkg::ACT_SEND, b, 1'b0, 8'h00, 1'b1);
  endtask

  // Work out the bus actions caused by one accepted input transfer
  task automatic next_bus_actions(input seq_item_t it);
    logic [7:0] st;
    st     = it.bus_status & i2cebas_pkg::STATUS_MASK;
    step_n = 0;
    if (it.cmd == i2cebas_pkg::CMD_WRITE || it.cmd == i2cebas_pkg::CMD_READ) begin
      if (seq_phase == SEQ_IDLE) begin
        read_q    = (it.cmd == i2cebas_pkg::CMD_READ);
        addr_q    = it.mem_addr;
        slave_q   = {it.dev_code, it.chip_sel};
        data_q    = read_q ? 8'h00 : it.wr_data;
        attempt_q = 4'd0;
        seq_phase = SEQ_START;
        emit_action(i2cebas_pkg::ACT_START, 8'h00, 1'b0, 8'h00, 1'b1);
      end
    end else if (it.cmd == i2cebas_pkg::CMD_EVENT && seq_phase != SEQ_IDLE) begin
      case (seq_phase)
        SEQ_START: begin
          if (st == i2cebas_pkg::ST_ARB_LOST) restart_access();
          else if (st != i2cebas_pkg::ST_START && st != i2cebas_pkg::ST_REP_START)
            close_access(1'b0);
          else send_byte({slave_q, 1'b0}, SEQ_SLA_W);
        end
        SEQ_SLA_W: begin
          if (st == i2cebas_pkg::ST_MT_SLA_NAK || st == i2cebas_pkg::ST_ARB_LOST)
            restart_access();
          else if (st != i2cebas_pkg::ST_MT_SLA_ACK) close_access(1'b0);
          else send_byte(addr_q[15:8], SEQ_ADDR_HI);
        end
        SEQ_ADDR_HI: begin
          if (st != i2cebas_pkg::ST_MT_DAT_ACK) close_access(1'b0);
          else send_byte(addr_q[7:0], SEQ_ADDR_LO);
        end
        SEQ_ADDR_LO: begin
          if (st != i2cebas_pkg::ST_MT_DAT_ACK) close_access(1'b0);
          else if (!read_q) send_byte(data_q, SEQ_DATA);
          else begin
            seq_phase = SEQ_RESTART;
            emit_action(i2cebas_pkg::ACT_START, 8'h00, 1'b0, 8'h00, 1'b1);
          end
        end
        SEQ_DATA: close_access(st == i2cebas_pkg::ST_MT_DAT_ACK);
        SEQ_RESTART: begin
          if (st == i2cebas_pkg::ST_ARB_LOST) restart_access();
          else if (st != i2cebas_pkg::ST_START && st != i2cebas_pkg::ST_REP_START)
            close_access(1'b0);
          else send_byte({slave_q, 1'b1}, SEQ_SLA_R);
        end
        SEQ_SLA_R: begin
          if (st == i2cebas_pkg::ST_MR_SLA_NAK || st == i2cebas_pkg::ST_ARB_LOST)
            restart_access();
          else if (st != i2cebas_pkg::ST_MR_SLA_ACK) close_access(1'b0);
          else begin
            seq_phase = SEQ_RX;
            emit_action(i2cebas_pkg::ACT_RECV, 8'h00, 1'b0, 8'h00, 1'b1);
          end
        end
        SEQ_RX: begin
          if (st != i2cebas_pkg::ST_MR_DAT_NAK) close_access(1'b0);
          else begin
            data_q = it.rx_data;
            close_access(1'b1);
          end
        end
        default: seq_phase = SEQ_IDLE;
      endcase
    end
  endtask

  // Drive one input transfer after a random gap, then record its actions
  task automatic transfer_item(input seq_item_t it, input int n_fixed,
                               input i2cebas_pkg::result_t f0,
                               input i2cebas_pkg::result_t f1);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {1'b0, it.rx_data, it.bus_status, it.wr_data, it.chip_sel, it.dev_code,
                 it.mem_addr};
    s_tuser  <= it.cmd;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    next_bus_actions(it);
    if (n_fixed >= 0) begin
      if (n_fixed > 0) pending_actions.push_back(f0);
      if (n_fixed > 1) pending_actions.push_back(f1);
    end else begin
      for (int k = 0; k < step_n; k++) pending_actions.push_back(step_out[k]);
    end
  endtask

  // Drop valid and let every outstanding action come out
  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_actions.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_actions.size() != 0) begin
      $display("%0t ns: %0d actions never arrived, first expected action %0d",
               $time, pending_actions.size(), pending_actions[0].action);
      mismatches++;
      pending_actions.delete();
    end
  endtask

  task automatic set_retry_limit(input logic [3:0] v);
    settle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    retry_limit = v;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed accesses, with setbacks, bad status and stray items mixed in
  task automatic pick_random_item(output seq_item_t it);
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    logic [7:0]  good;
    logic [7:0]  setback;
    int          roll;
    r1 = $urandom;
    r2 = $urandom;
    r3 = $urandom;
    it.mem_addr   = r1[15:0];
    it.wr_data    = r1[23:16];
    it.rx_data    = r1[31:24];
    it.bus_status = r2[7:0];
    it.dev_code   = r2[11:8];
    it.chip_sel   = r2[14:12];
    roll = $urandom_range(0, 99);
    if (seq_phase == SEQ_IDLE) begin
      flaky = (r3[2:0] == 3'd0);
      if (roll < 85) it.cmd = r2[15] ? i2cebas_pkg::CMD_READ : i2cebas_pkg::CMD_WRITE;
      else if (roll < 95) it.cmd = i2cebas_pkg::CMD_EVENT;
      else it.cmd = CMD_UNUSED;
    end else if (roll < 4) begin
      it.cmd = r2[15] ? i2cebas_pkg::CMD_READ : i2cebas_pkg::CMD_WRITE;
    end else if (roll < 6) begin
      it.cmd = CMD_UNUSED;
    end else begin
      it.cmd = i2cebas_pkg::CMD_EVENT;
      case (seq_phase)
        SEQ_START, SEQ_RESTART: begin
          good    = r2[16] ? i2cebas_pkg::ST_START : i2cebas_pkg::ST_REP_START;
          setback = i2cebas_pkg::ST_ARB_LOST;
        end
        SEQ_SLA_W: begin
          good    = i2cebas_pkg::ST_MT_SLA_ACK;
          setback = r2[16] ? i2cebas_pkg::ST_MT_SLA_NAK : i2cebas_pkg::ST_ARB_LOST;
        end
        SEQ_SLA_R: begin
          good    = i2cebas_pkg::ST_MR_SLA_ACK;
          setback = r2[16] ? i2cebas_pkg::ST_MR_SLA_NAK : i2cebas_pkg::ST_ARB_LOST;
        end
        SEQ_RX: begin
          good    = i2cebas_pkg::ST_MR_DAT_NAK;
          setback = i2cebas_pkg::ST_MT_DAT_ACK;
        end
        default: begin
          good    = i2cebas_pkg::ST_MT_DAT_ACK;
          setback = i2cebas_pkg::ST_MT_SLA_NAK;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < (flaky ? 90 : 8)) it.bus_status = {setback[7:3], r2[2:0]};
      else if (roll >= (flaky ? 95 : 14)) it.bus_status = {good[7:3], r2[2:0]};
    end
  endtask

  // Check each action against the oldest expectation
  always @(posedge clk) begin : check_actions
    i2cebas_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_actions.size() == 0) begin
        $display("%0t ns: unexpected action: expected none, actual action %0d tx %0h",
                 $time, m_tuser, m_tdata[7:0]);
        mismatches++;
      end else begin
        want = pending_actions.pop_front();
        check_field("bus_action", 8'(want.action), 8'(m_tuser));
        check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
        check_field("success", 8'(want.success), 8'(m_tdata[8]));
        check_field("read_byte", want.read_byte, m_tdata[16:9]);
        check_field("last", 8'(want.last), 8'(m_tlast));
      end
    end
  end

  // Stall the action channel at random
  initial begin : action_sink
    int stall;
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && !rst)) @(posedge clk);
    end
  end

  initial begin : stimulus
    localparam logic [3:0] LIMIT_SWEEP [3] = '{4'd15, 4'd0, 4'd5};
    seq_item_t all_ones;
    seq_item_t it;
    i2cebas_pkg::result_t start_ok;
    i2cebas_pkg::result_t stop_r;
    int        caused;
    logic [3:0] lim;

    all_ones = '1;   // kind field all ones is the unused code
    start_ok = outcome(i2cebas_pkg::ACT_START, 8'h00, 1'b0, 8'h00, 1'b1);
    stop_r   = outcome(i2cebas_pkg::ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0);

    // Directed steps, retry limit at its reset value
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_START, 8'h00), 0)); // event while idle
    plan.push_back(send_row(all_ones, 0));                                  // unused kind
    plan.push_back(send_row(request(i2cebas_pkg::CMD_WRITE, 16'hFFFF, 4'hF, 3'h7, 8'hFF),
                            1, start_ok));
    plan.push_back(send_row(request(i2cebas_pkg::CMD_READ, 16'h1234, 4'h3, 3'h2, 8'h55),
                            0)); // busy
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_START | 8'h07, 8'h00), 1,
                            outcome(i2cebas_pkg::ACT_SEND, 8'hFE, 1'b0, 8'h00, 1'b1)));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MT_SLA_ACK, 8'h00), 1,
                            outcome(i2cebas_pkg::ACT_SEND, 8'hFF, 1'b0, 8'h00, 1'b1)));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MT_DAT_ACK, 8'h00), 1,
                            outcome(i2cebas_pkg::ACT_SEND, 8'hFF, 1'b0, 8'h00, 1'b1)));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MT_DAT_ACK, 8'h00), 1,
                            outcome(i2cebas_pkg::ACT_SEND, 8'hFF, 1'b0, 8'h00, 1'b1)));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MT_DAT_ACK, 8'h00), 2, stop_r,
                            outcome(i2cebas_pkg::ACT_DONE, 8'h00, 1'b1, 8'h00, 1'b1)));
    plan.push_back(send_row(request(i2cebas_pkg::CMD_READ, 16'h0000, 4'h0, 3'h0, 8'h00),
                            1, start_ok));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_REP_START, 8'h00), 1,
                            outcome(i2cebas_pkg::ACT_SEND, 8'h00, 1'b0, 8'h00, 1'b1)));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MT_SLA_NAK, 8'h00), -1));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_ARB_LOST, 8'h00), -1));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_START, 8'h00), -1));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MT_SLA_ACK, 8'h00), -1));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MT_DAT_ACK, 8'h00), -1));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MT_DAT_ACK, 8'h00), -1));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_REP_START, 8'h00), -1));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MR_SLA_ACK, 8'h00), -1));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_MR_DAT_NAK, 8'hFF), 2, stop_r,
                            outcome(i2cebas_pkg::ACT_DONE, 8'h00, 1'b1, 8'hFF, 1'b1)));
    plan.push_back(send_row(request(i2cebas_pkg::CMD_WRITE, 16'h00A5, 4'h5, 3'h2, 8'h3C),
                            -1));
    plan.push_back(send_row(status_item(8'hFF, 8'hFF), 2, stop_r,         // bad status
                            outcome(i2cebas_pkg::ACT_DONE, 8'h00, 1'b0, 8'h00, 1'b1)));
    // Retries exhausted at once: fail with no stop
    plan.push_back(limit_row(4'd0));
    plan.push_back(send_row(request(i2cebas_pkg::CMD_READ, 16'h8001, 4'hA, 3'h5, 8'h00),
                            1, start_ok));
    plan.push_back(send_row(status_item(i2cebas_pkg::ST_ARB_LOST, 8'h00), 1,
                            outcome(i2cebas_pkg::ACT_DONE, 8'h00, 1'b0, 8'h00, 1'b1)));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_limit) set_retry_limit(plan[i].limit);
      else transfer_item(plan[i].item, plan[i].n_fixed, plan[i].fixed0, plan[i].fixed1);
    end

    // Random phases; each ends with the sequencer idle before the next limit write
    for (int p = 0; p < 6; p++) begin
      lim = (p % 2 == 1) ? 4'($urandom_range(1, 14)) : LIMIT_SWEEP[p / 2];
      set_retry_limit(lim);
      caused = 0;
      while (caused < 195 || seq_phase != SEQ_IDLE) begin
        pick_random_item(it);
        transfer_item(it, -1, NO_RESULT, NO_RESULT);
        if (step_n > 0) caused++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
